@@ sv/ps2mpf_pkg.sv @@
// ps2mpf_pkg: shared types and codes for the ps2 mouse packet queue
// used by ps2mpf_queue, ps2_mouse_packet_fifo_core and ps2mpf_checker
// no dependencies
package ps2mpf_pkg;

   localparam int unsigned BUTTON_W = 3;
   localparam int unsigned MOTION_W = 8;
   localparam int unsigned BYTE_W   = 8;

   // request opcode carried on req_op
   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // which byte of the packet comes next
   typedef enum logic [1:0] {
      PHASE_BUTTONS = 2'd0,
      PHASE_X       = 2'd1,
      PHASE_Y       = 2'd2
   } phase_type;

   // one queued packet
   typedef struct packed {
      logic [BUTTON_W-1:0]        buttons;
      logic signed [MOTION_W-1:0] x;
      logic signed [MOTION_W-1:0] y;
   } packet_type;

   // queue commands from the assembler
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   // queue occupancy flags
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

@@ sv/ps2_mouse_packet_fifo_core.sv @@
// ps2_mouse_packet_fifo_core: ps2 mouse byte assembler feeding a packet queue
// depends on ps2mpf_pkg and ps2mpf_queue
//
//   channel  | handshake           | fields                                  | beat
//   req, in  | req_valid/req_ready | req_op, req_data_byte                   | mouse byte or read
//   rsp, out | rsp_valid/rsp_ready | rsp_packet_valid, rsp_button_bits, x/y  | one per read
//
// one req beat per cycle while req_ready is high; a read answers in the next cycle from the registered
// storage read port, which sets the latency
// req_ready drops only while a response sits unclaimed with rsp_ready low
// byte beats and reads go through the same registered update of phase,
// pointers and fill count
// synchronous reset clears phase, held bytes, pointers, count and rsp_valid;
// storage contents are not cleared (only counted entries are ever read)
module ps2_mouse_packet_fifo_core #(
   parameter int unsigned QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_packet_valid,
   output logic [2:0]  rsp_button_bits,
   output logic signed [7:0] rsp_x_motion,
   output logic signed [7:0] rsp_y_motion
);

   // handshake and decode
   logic accept;
   logic is_byte;
   logic is_read;

   // byte phase state machine
   ps2mpf_pkg::phase_type phase_ff, phase_in;
   logic load_buttons;
   logic load_x;
   logic complete;

   // held first and second bytes
   logic [ps2mpf_pkg::BUTTON_W-1:0] held_buttons_ff;
   logic [ps2mpf_pkg::MOTION_W-1:0] held_x_ff;

   // queue interface
   ps2mpf_pkg::queue_ctrl_type   q_ctrl;
   ps2mpf_pkg::queue_status_type q_status;
   ps2mpf_pkg::packet_type       wr_packet;
   ps2mpf_pkg::packet_type       rd_packet;

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_packet_valid_ff;

   // stall only when a response is pending and not being taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_byte   = accept && (ps2mpf_pkg::op_type'(req_op) == ps2mpf_pkg::OP_BYTE);
   assign is_read   = accept && (ps2mpf_pkg::op_type'(req_op) == ps2mpf_pkg::OP_READ);

   // next phase: advance on every byte beat, wrap after the third
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         ps2mpf_pkg::PHASE_BUTTONS: if (is_byte) phase_in = ps2mpf_pkg::PHASE_X;
         ps2mpf_pkg::PHASE_X:       if (is_byte) phase_in = ps2mpf_pkg::PHASE_Y;
         ps2mpf_pkg::PHASE_Y:       if (is_byte) phase_in = ps2mpf_pkg::PHASE_BUTTONS;
         default:                   if (is_byte) phase_in = ps2mpf_pkg::PHASE_X;
      endcase
   end

   // phase outputs: which byte gets captured, and packet completion
   always_comb begin
      load_buttons = 1'b0;
      load_x       = 1'b0;
      complete     = 1'b0;
      case (phase_ff)
         ps2mpf_pkg::PHASE_BUTTONS: load_buttons = is_byte;
         ps2mpf_pkg::PHASE_X:       load_x       = is_byte;
         ps2mpf_pkg::PHASE_Y:       complete     = is_byte;
         default:                   load_buttons = is_byte;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ps2mpf_pkg::PHASE_BUTTONS;
         held_buttons_ff <= '0;
         held_x_ff       <= '0;
      end else begin
         phase_ff <= phase_in;
         if (load_buttons) begin
            held_buttons_ff <= req_data_byte[ps2mpf_pkg::BUTTON_W-1:0];
         end
         if (load_x) begin
            held_x_ff <= req_data_byte;
         end
      end
   end

   // packet build; y is the third byte negated with 8-bit wrap
   assign wr_packet.buttons = held_buttons_ff;
   assign wr_packet.x       = held_x_ff;
   assign wr_packet.y       = ps2mpf_pkg::MOTION_W'(8'd0 - req_data_byte);

   // full queue drops the packet; empty queue answers with no packet
   assign q_ctrl.push = complete && !q_status.full;
   assign q_ctrl.pop  = is_read && !q_status.empty;

   ps2mpf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (q_ctrl),
      .wr_packet (wr_packet),
      .status    (q_status),
      .rd_packet (rd_packet)
   );

   // response valid: set by a read beat, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (is_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_read) begin
         rsp_packet_valid_ff <= !q_status.empty;
      end
   end

   // empty answer shows zeros in every field
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packet_valid = rsp_packet_valid_ff;
   assign rsp_button_bits  = rsp_packet_valid_ff ? rd_packet.buttons : '0;
   assign rsp_x_motion     = rsp_packet_valid_ff ? rd_packet.x : '0;
   assign rsp_y_motion     = rsp_packet_valid_ff ? rd_packet.y : '0;

endmodule

@@ sv/ps2mpf_queue.sv @@
// ps2mpf_queue: circular packet store with pointers and fill count
// depends on ps2mpf_pkg
// read data is registered and held until the next pop
module ps2mpf_queue #(
   parameter int unsigned QUEUE_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ps2mpf_pkg::queue_ctrl_type   ctrl,
   input  ps2mpf_pkg::packet_type       wr_packet,
   output ps2mpf_pkg::queue_status_type status,
   output ps2mpf_pkg::packet_type       rd_packet
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   ps2mpf_pkg::packet_type mem [QUEUE_DEPTH];
   ps2mpf_pkg::packet_type rd_packet_ff;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_FULL);
   assign rd_packet    = rd_packet_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in  = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         count_in  = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write port
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wr_ptr_ff] <= wr_packet;
      end
   end

   // storage read port, registered
   always_ff @(posedge clock) begin
      if (ctrl.pop) begin
         rd_packet_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

@@ sv/ps2mpf_checker.sv @@
// ps2mpf_checker: port-level checks for ps2_mouse_packet_fifo_core
// depends on ps2mpf_pkg; bound to the top level below
module ps2mpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_op,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_packet_valid,
   input logic [2:0]  rsp_button_bits,
   input logic signed [7:0] rsp_x_motion,
   input logic signed [7:0] rsp_y_motion
);

   logic byte_beat;
   logic read_beat;

   assign byte_beat = req_valid && req_ready &&
                      (ps2mpf_pkg::op_type'(req_op) == ps2mpf_pkg::OP_BYTE);
   assign read_beat = req_valid && req_ready &&
                      (ps2mpf_pkg::op_type'(req_op) == ps2mpf_pkg::OP_READ);

   // a stalled response keeps its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packet_valid) &&
      $stable(rsp_button_bits) && $stable(rsp_x_motion) && $stable(rsp_y_motion))
      else $error("response changed while stalled");

   // every accepted read answers in the next cycle
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      read_beat |=> rsp_valid)
      else $error("read beat gave no response");

   // a byte beat never creates a response
   a_byte_silent: assert property (@(posedge clock) disable iff (reset)
      byte_beat && !rsp_valid |=> !rsp_valid)
      else $error("byte beat produced a response");

   // the request side stalls only behind an unclaimed response
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a pending response");

   // an empty answer carries zero fields
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_packet_valid |->
      rsp_button_bits == 3'd0 && rsp_x_motion == 8'sd0 && rsp_y_motion == 8'sd0)
      else $error("empty answer with nonzero fields");

endmodule

bind ps2_mouse_packet_fifo_core ps2mpf_checker u_ps2mpf_checker (.*);

@@ verif/ps2mpf_checker.sv @@
// ps2mpf_scoreboard: watches the req and rsp channels of the mouse packet queue,
// predicts every read answer and compares it field by field
// depends on ps2mpf_pkg
module ps2mpf_scoreboard #(
   parameter int unsigned QUEUE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_op,
   input  logic [7:0]        req_data_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_packet_valid,
   input  logic [2:0]        rsp_button_bits,
   input  logic signed [7:0] rsp_x_motion,
   input  logic signed [7:0] rsp_y_motion,
   output int                fail_count,
   output int                reads_waiting,
   output int                beats_seen,
   output int                packets_returned,
   output int                empty_reads,
   output int                packets_dropped
);

   typedef struct packed {
      logic                   present;
      ps2mpf_pkg::packet_type pkt;
   } answer_type;

   ps2mpf_pkg::phase_type           phase;
   logic [ps2mpf_pkg::BUTTON_W-1:0] held_buttons;
   logic [ps2mpf_pkg::MOTION_W-1:0] held_x;
   ps2mpf_pkg::packet_type          packet_queue[$];
   answer_type                      answers_due[$];

   initial begin
      fail_count       = 0;
      reads_waiting    = 0;
      beats_seen       = 0;
      packets_returned = 0;
      empty_reads      = 0;
      packets_dropped  = 0;
   end

   always @(posedge clock) begin
      answer_type             want;
      ps2mpf_pkg::packet_type built;
      logic                   answered;
      logic                   asked;
      if (reset) begin
         phase = ps2mpf_pkg::PHASE_BUTTONS;
         held_buttons = '0;
         held_x = '0;
         packet_queue.delete();
         answers_due.delete();
         reads_waiting <= 0;
      end else begin
         answered = rsp_valid && rsp_ready;
         asked = req_valid && req_ready && req_op == ps2mpf_pkg::OP_READ;

         // the answer leaving now belongs to a read taken at an earlier edge
         if (answered) begin
            if (rsp_packet_valid) packets_returned++;
            else empty_reads++;
            if (answers_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: rsp beat with nothing expected: valid=%0b btn=%0d x=%0d y=%0d",
                           $time, rsp_packet_valid, rsp_button_bits, rsp_x_motion,
                           rsp_y_motion);
            end else begin
               want = answers_due.pop_front();
               if (rsp_packet_valid !== want.present ||
                   rsp_button_bits !== want.pkt.buttons ||
                   rsp_x_motion !== want.pkt.x || rsp_y_motion !== want.pkt.y) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: rsp mismatch exp valid=%0b btn=%0d x=%0d y=%0d,",
                               " got valid=%0b btn=%0d x=%0d y=%0d"},
                              $time, want.present, want.pkt.buttons, want.pkt.x,
                              want.pkt.y, rsp_packet_valid, rsp_button_bits,
                              rsp_x_motion, rsp_y_motion);
               end
            end
         end

         if (req_valid && req_ready) begin
            beats_seen++;
            if (req_op == ps2mpf_pkg::OP_READ) begin
               if (packet_queue.size() == 0) begin
                  want = '0;
               end else begin
                  want.present = 1'b1;
                  want.pkt = packet_queue.pop_front();
               end
               answers_due.push_back(want);
            end else begin
               case (phase)
                  ps2mpf_pkg::PHASE_X: begin
                     held_x = req_data_byte;
                     phase = ps2mpf_pkg::PHASE_Y;
                  end
                  ps2mpf_pkg::PHASE_Y: begin
                     phase = ps2mpf_pkg::PHASE_BUTTONS;
                     built.buttons = held_buttons;
                     built.x = held_x;
                     built.y = 8'd0 - req_data_byte;
                     // a full queue drops the whole packet
                     if (packet_queue.size() >= QUEUE_DEPTH) packets_dropped++;
                     else packet_queue.push_back(built);
                  end
                  default: begin
                     held_buttons = req_data_byte[ps2mpf_pkg::BUTTON_W-1:0];
                     phase = ps2mpf_pkg::PHASE_X;
                  end
               endcase
            end
         end

         reads_waiting <= reads_waiting + int'(asked) - int'(answered);
      end
   end

endmodule

@@ verif/ps2_mouse_packet_fifo_core_test.sv @@
// ps2_mouse_packet_fifo_core_test: stimulus and verdict for the mouse packet queue
// drives mouse bytes and reads into ps2_mouse_packet_fifo_core, checking is done by
// ps2mpf_scoreboard; depends on ps2mpf_pkg
module ps2_mouse_packet_fifo_core_test;

   localparam int unsigned QUEUE_DEPTH = 64;
   // slowest run is about 450 beats
   localparam int CYCLE_LIMIT  = 200000;
   // read answers come in the cycle after the read beat
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      ps2mpf_pkg::op_type op;
      logic [7:0]         data;
   } beat_type;

   // every block input starts at a known value
   logic clock         = 1'b0;
   logic reset         = 1'b1;
   logic req_valid     = 1'b0;
   logic req_op        = ps2mpf_pkg::OP_BYTE;
   logic [7:0] req_data_byte = 8'h00;
   logic rsp_ready     = 1'b0;

   logic              req_ready;
   logic              rsp_valid;
   logic              rsp_packet_valid;
   logic [2:0]        rsp_button_bits;
   logic signed [7:0] rsp_x_motion;
   logic signed [7:0] rsp_y_motion;

   int fail_count;
   int reads_waiting;
   int beats_seen;
   int packets_returned;
   int empty_reads;
   int packets_dropped;

   int   cycle_count = 0;
   int   stall_left  = 0;
   // no idling on either side once set
   logic steady      = 1'b0;

   // opening beats: empty read, field extremes, y negation corners,
   // button masking of high bits, a read in the middle of a packet
   beat_type opening[$] = '{
      '{ps2mpf_pkg::OP_READ, 8'hFF},
      '{ps2mpf_pkg::OP_BYTE, 8'hFF}, '{ps2mpf_pkg::OP_BYTE, 8'h80},
      '{ps2mpf_pkg::OP_BYTE, 8'h80},                                 // y -128 stays -128
      '{ps2mpf_pkg::OP_BYTE, 8'h08}, '{ps2mpf_pkg::OP_BYTE, 8'h7F},
      '{ps2mpf_pkg::OP_BYTE, 8'h7F},                                 // bit 3 of the button byte is masked off
      '{ps2mpf_pkg::OP_BYTE, 8'h00}, '{ps2mpf_pkg::OP_BYTE, 8'h00},
      '{ps2mpf_pkg::OP_BYTE, 8'h00},
      '{ps2mpf_pkg::OP_BYTE, 8'hFA}, '{ps2mpf_pkg::OP_BYTE, 8'h01},
      '{ps2mpf_pkg::OP_BYTE, 8'hFF},
      '{ps2mpf_pkg::OP_BYTE, 8'h05}, '{ps2mpf_pkg::OP_BYTE, 8'hFF},
      '{ps2mpf_pkg::OP_BYTE, 8'h01},
      '{ps2mpf_pkg::OP_READ, 8'h00}, '{ps2mpf_pkg::OP_READ, 8'h5A},
      '{ps2mpf_pkg::OP_READ, 8'hA5},
      '{ps2mpf_pkg::OP_BYTE, 8'h03}, '{ps2mpf_pkg::OP_READ, 8'h00},  // read between bytes
      '{ps2mpf_pkg::OP_BYTE, 8'h10}, '{ps2mpf_pkg::OP_BYTE, 8'h20},
      '{ps2mpf_pkg::OP_READ, 8'h00}, '{ps2mpf_pkg::OP_READ, 8'hFF}
   };

   ps2_mouse_packet_fifo_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packet_valid(rsp_packet_valid),
      .rsp_button_bits (rsp_button_bits),
      .rsp_x_motion    (rsp_x_motion),
      .rsp_y_motion    (rsp_y_motion)
   );

   ps2mpf_scoreboard #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packet_valid(rsp_packet_valid),
      .rsp_button_bits (rsp_button_bits),
      .rsp_x_motion    (rsp_x_motion),
      .rsp_y_motion    (rsp_y_motion),
      .fail_count      (fail_count),
      .reads_waiting   (reads_waiting),
      .beats_seen      (beats_seen),
      .packets_returned(packets_returned),
      .empty_reads     (empty_reads),
      .packets_dropped (packets_dropped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // receiver: random bursts of stalled cycles, none in the steady tail
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if ($urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(1, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // mostly uniform bytes, with the sign and range corners mixed in
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'h80;
         2: return 8'h7F;
         3: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // one req beat; valid may drop for a random gap first, then holds until taken
   task automatic send_beat(input ps2mpf_pkg::op_type op, input logic [7:0] data);
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // sender goes quiet until every read has been answered
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reads_waiting != 0) @(posedge clock);
   endtask

   // timeout guard
   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("ps2_mouse_packet_fifo_core_test NOT OK");
      $finish;
   end

   initial begin
      int read_pct;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send_beat(opening[i].op, opening[i].data);

      // fill past the queue depth so the last packets are dropped
      repeat (3 * (QUEUE_DEPTH + 2)) send_beat(ps2mpf_pkg::OP_BYTE, pick_byte());
      // drain it and keep reading into the empty queue
      repeat (QUEUE_DEPTH + 6) send_beat(ps2mpf_pkg::OP_READ, 8'($urandom));

      wait_for_answers();

      // mixed traffic in chunks, each with its own read share; the tail runs
      // without idling on either side
      for (int chunk = 0; chunk < 6; chunk++) begin
         read_pct = $urandom_range(10, 70);
         if (chunk == 4) steady <= 1'b1;
         repeat (25) begin
            if ($urandom_range(1, 100) <= read_pct)
               send_beat(ps2mpf_pkg::OP_READ, 8'($urandom));
            else
               send_beat(ps2mpf_pkg::OP_BYTE, pick_byte());
         end
      end

      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d req beats, %0d packets read back, %0d reads of an empty queue",
               beats_seen, packets_returned, empty_reads);
      $display("queue overfilled with %0d packets dropped, sender and receiver idling at random",
               packets_dropped);
      if (fail_count == 0) begin
         $display("ps2_mouse_packet_fifo_core_test OK");
      end else begin
         $display("ps2_mouse_packet_fifo_core_test NOT OK");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/ps2mpf_pkg.sv
sv/ps2mpf_queue.sv
sv/ps2_mouse_packet_fifo_core.sv
sv/ps2mpf_checker.sv
verif/ps2mpf_checker.sv
verif/ps2_mouse_packet_fifo_core_test.sv
